@@ rtl/core/rcbind_pkg.sv @@
// shared types and constants of the rc bind and control packet transmitter
`timescale 1ns / 1ps

package rcbind_pkg;

    // stick clamp limit and the reciprocal used to divide by it
    localparam int          CHANNEL_LIMIT = 10000;
    localparam int          LIM_W         = $clog2(CHANNEL_LIMIT + 1);
    localparam int          RECIP_SHIFT   = 40;
    localparam longint      RECIP         = ((64'd1 << RECIP_SHIFT) + CHANNEL_LIMIT - 1)
                                            / CHANNEL_LIMIT;
    localparam int          RECIP_W       = $clog2(RECIP + 1);
    localparam int          PROD_W        = LIM_W + 8 + RECIP_W;

    // packet geometry
    localparam int          PKT_BYTES     = 9;
    localparam int          IDX_W         = 4;

    // queue between the packet builder and the byte serializer
    localparam int          Q_DEPTH       = 4;
    localparam int          Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int          Q_CNT_W       = $clog2(Q_DEPTH + 1);

    // configuration register indexes
    localparam int          CFG_IDX_W     = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_ID    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIND_REP = 2'd3;

    localparam logic [7:0]  BIND_REP_RESET = 8'd60;

    // packet formats with special handling
    localparam logic [2:0]  FMT_BASE      = 3'd0;
    localparam logic [2:0]  FMT_RUD_INV   = 3'd2;
    localparam logic [2:0]  FMT_BIND_ZERO = 3'd3;

    // acknowledge codes
    localparam logic [1:0]  ACK_PENDING   = 2'd0;
    localparam logic [1:0]  ACK_OK        = 2'd1;
    localparam logic [1:0]  ACK_FAIL      = 2'd2;
    localparam logic [1:0]  ACK_BOTH      = 2'd3;

    // fixed bytes
    localparam logic [7:0]  BIND_B4       = 8'h56;
    localparam logic [7:0]  BIND_B5       = 8'hAA;
    localparam logic [7:0]  BIND_B6       = 8'h32;
    localparam logic [7:0]  FLG_FLIP      = 8'h0F;
    localparam logic [7:0]  FLG_LIGHT     = 8'h80;
    localparam logic [7:0]  FLG_PICTURE   = 8'h40;
    localparam logic [7:0]  FLG_VIDEO     = 8'h20;
    localparam logic [7:0]  FLG_HEADLESS  = 8'h10;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_BIND,
        PH_CHECK,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic [2:0]  fmt;
        logic        auto_ack_off;
        logic [31:0] tx_id;
        logic [7:0]  bind_rep;
    } t_cfg;

    // one queued tick: a packet or an empty result
    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          nbytes;
        logic                      sending;
        logic                      bind_addr;
        logic                      soon;
        logic                      done;
    } t_pkt;

endpackage

@@ rtl/core/rcbind_front.sv @@
// front end: takes ticks, scales sticks, runs the link sequence and builds packets
`timescale 1ns / 1ps

module rcbind_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rcbind_pkg::t_cfg     i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [70:0]          i_data,
    output logic                 o_push,
    output rcbind_pkg::t_pkt     o_pkt,
    input  logic                 i_q_ready
);

    // clamp, take magnitude and divide by the limit: q = |ch| * 255 / limit
    function automatic logic [7:0] stick_quot(input logic [15:0] ch);
        logic [16:0]                          mag17;
        logic [rcbind_pkg::LIM_W-1:0]         mag;
        logic [rcbind_pkg::LIM_W+7:0]         m;
        logic [rcbind_pkg::PROD_W-1:0]        prod;
        mag17 = ch[15] ? (17'd0 - {ch[15], ch}) : {1'b0, ch};
        if (mag17 > 17'(rcbind_pkg::CHANNEL_LIMIT)) begin
            mag = rcbind_pkg::LIM_W'(rcbind_pkg::CHANNEL_LIMIT);
        end else begin
            mag = mag17[rcbind_pkg::LIM_W-1:0];
        end
        m    = ({mag, 8'd0}) - (rcbind_pkg::LIM_W+8)'(mag);
        prod = rcbind_pkg::PROD_W'(m) * rcbind_pkg::PROD_W'(rcbind_pkg::RECIP);
        return prod[rcbind_pkg::RECIP_SHIFT +: 8];
    endfunction

    // (256 +- q) >> 1
    function automatic logic [7:0] stick_byte(input logic sgn, input logic [7:0] q);
        logic [8:0] d;
        d = 9'h100 - {1'b0, q};
        return sgn ? d[8:1] : {1'b1, q[7:1]};
    endfunction

    // stage a: scaled sticks, flags and ack
    logic                 r_a_vld;
    logic [7:0]           r_a_q   [4];
    logic [3:0]           r_a_sgn;
    logic [7:0]           r_a_flg;
    logic [1:0]           r_a_ack;

    // link sequence state
    rcbind_pkg::t_phase   r_phase, n_phase;
    logic [7:0]           r_bind_left, n_bind_left;
    logic                 r_addr_bind, n_addr_bind;

    logic                 adv;
    logic [1:0]           ack;
    logic                 snd_data, snd_bind, emp_soon, emp_done;
    logic [7:0]           ail, ele, thr, rud, ail_t, ele_t, rud_t;
    logic [7:0]           d_byte [8];
    logic [7:0]           b_byte [8];
    logic [7:0]           sum;
    logic [7:0]           flg;

    assign adv     = !r_a_vld || i_q_ready;
    assign o_ready = adv;
    assign o_push  = r_a_vld && i_q_ready;

    always_comb begin
        flg = 8'd0;
        if (i_data[64]) flg = flg | rcbind_pkg::FLG_FLIP;
        if (i_data[65]) flg = flg | rcbind_pkg::FLG_LIGHT;
        if (i_data[66]) flg = flg | rcbind_pkg::FLG_PICTURE;
        if (i_data[67]) flg = flg | rcbind_pkg::FLG_VIDEO;
        if (i_data[68]) flg = flg | rcbind_pkg::FLG_HEADLESS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_valid;
        end
    end

    // sticks in word order: aileron, elevator, throttle, rudder
    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            for (int k = 0; k < 4; k++) begin
                r_a_q[k]   <= stick_quot(i_data[16*k +: 16]);
                r_a_sgn[k] <= i_data[16*k + 15];
            end
            r_a_flg <= flg;
            r_a_ack <= i_data[70:69];
        end
    end

    // effective ack: ok while auto-ack is off, else both bits set counts as pending
    always_comb begin
        if (i_cfg.auto_ack_off) begin
            ack = rcbind_pkg::ACK_OK;
        end else if (r_a_ack == rcbind_pkg::ACK_BOTH) begin
            ack = rcbind_pkg::ACK_PENDING;
        end else begin
            ack = r_a_ack;
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_bind_left = r_bind_left;
        n_addr_bind = r_addr_bind;
        case (r_phase)
            rcbind_pkg::PH_INIT: begin
                if (!i_cfg.auto_ack_off) begin
                    n_phase = rcbind_pkg::PH_CHECK;
                end else begin
                    n_addr_bind = 1'b1;
                    n_bind_left = i_cfg.bind_rep;
                    n_phase     = rcbind_pkg::PH_BIND;
                end
            end
            rcbind_pkg::PH_BIND: begin
                if (ack != rcbind_pkg::ACK_PENDING) begin
                    if (r_bind_left == 8'd0) begin
                        n_addr_bind = 1'b0;
                        n_phase     = rcbind_pkg::PH_CHECK;
                    end else begin
                        n_bind_left = r_bind_left - 8'd1;
                    end
                end
            end
            rcbind_pkg::PH_CHECK: begin
                if (ack == rcbind_pkg::ACK_OK) begin
                    n_phase = rcbind_pkg::PH_DATA;
                end else if (ack == rcbind_pkg::ACK_FAIL) begin
                    n_addr_bind = 1'b1;
                    n_bind_left = i_cfg.bind_rep;
                    n_phase     = rcbind_pkg::PH_BIND;
                end
            end
            default: begin
            end
        endcase
    end

    // what this tick produces
    always_comb begin
        snd_data = 1'b0;
        snd_bind = 1'b0;
        emp_soon = 1'b0;
        emp_done = 1'b0;
        case (r_phase)
            rcbind_pkg::PH_INIT: begin
                snd_bind = i_cfg.auto_ack_off;
                snd_data = !i_cfg.auto_ack_off;
            end
            rcbind_pkg::PH_BIND: begin
                if (ack == rcbind_pkg::ACK_PENDING) begin
                    emp_soon = 1'b1;
                end else if (r_bind_left == 8'd0) begin
                    snd_data = 1'b1;
                end else begin
                    snd_bind = 1'b1;
                end
            end
            rcbind_pkg::PH_CHECK: begin
                if (ack == rcbind_pkg::ACK_PENDING) begin
                    emp_soon = 1'b1;
                end else if (ack == rcbind_pkg::ACK_OK) begin
                    emp_done = 1'b1;
                end else begin
                    snd_bind = 1'b1;
                end
            end
            default: begin
                if (ack == rcbind_pkg::ACK_PENDING) begin
                    emp_soon = 1'b1;
                end else begin
                    snd_data = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rcbind_pkg::PH_INIT;
            r_bind_left <= 8'd0;
            r_addr_bind <= 1'b0;
        end else if (o_push) begin
            r_phase     <= n_phase;
            r_bind_left <= n_bind_left;
            r_addr_bind <= n_addr_bind;
        end
    end

    // data and bind packet bytes
    always_comb begin
        thr = stick_byte(r_a_sgn[2], r_a_q[2]);
        ele = stick_byte(r_a_sgn[1], r_a_q[1]);
        ail = 8'hFF - stick_byte(r_a_sgn[0], r_a_q[0]);
        if (i_cfg.fmt == rcbind_pkg::FMT_RUD_INV) begin
            rud   = stick_byte(r_a_sgn[3], r_a_q[3]);
            rud_t = (8'hFF - rud) >> 1;
        end else begin
            rud   = 8'hFF - stick_byte(r_a_sgn[3], r_a_q[3]);
            rud_t = rud >> 1;
        end
        ele_t = ele >> 1;
        ail_t = ail >> 1;
        d_byte[0] = thr;
        d_byte[1] = rud;
        d_byte[3] = ele;
        d_byte[4] = ail;
        if (i_cfg.fmt == rcbind_pkg::FMT_BASE) begin
            d_byte[2] = ele_t;
            d_byte[5] = ail_t;
            d_byte[6] = rud_t;
        end else begin
            d_byte[2] = rud_t;
            d_byte[5] = ele_t;
            d_byte[6] = ail_t;
        end
        d_byte[7] = r_a_flg;

        b_byte[0] = i_cfg.tx_id[31:24];
        b_byte[1] = i_cfg.tx_id[23:16];
        b_byte[2] = i_cfg.tx_id[15:8];
        b_byte[3] = i_cfg.tx_id[7:0];
        b_byte[4] = rcbind_pkg::BIND_B4;
        b_byte[5] = rcbind_pkg::BIND_B5;
        b_byte[6] = (i_cfg.fmt == rcbind_pkg::FMT_BIND_ZERO) ? 8'h00 : rcbind_pkg::BIND_B6;
        b_byte[7] = 8'h00;
    end

    // assemble the queue entry
    always_comb begin
        o_pkt           = '0;
        o_pkt.bind_addr = n_addr_bind;
        sum             = 8'd0;
        if (snd_data || snd_bind) begin
            for (int k = 0; k < 8; k++) begin
                o_pkt.bytes[k] = snd_bind ? b_byte[k] : d_byte[k];
                sum            = sum + o_pkt.bytes[k];
            end
            o_pkt.sending = 1'b1;
            if (i_cfg.fmt == rcbind_pkg::FMT_BASE) begin
                o_pkt.nbytes = rcbind_pkg::IDX_W'(8);
            end else begin
                o_pkt.bytes[8] = ~sum;
                o_pkt.nbytes   = rcbind_pkg::IDX_W'(rcbind_pkg::PKT_BYTES);
            end
        end else begin
            o_pkt.nbytes = rcbind_pkg::IDX_W'(1);
            o_pkt.soon   = emp_soon;
            o_pkt.done   = emp_done;
        end
    end

endmodule

@@ rtl/core/rcbind_queue.sv @@
// short fifo of built packets between the front end and the serializer
`timescale 1ns / 1ps

module rcbind_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rcbind_pkg::t_pkt     i_pkt,
    output logic                 o_ready,
    input  logic                 i_pop,
    output logic                 o_nonempty,
    output rcbind_pkg::t_pkt     o_head
);

    rcbind_pkg::t_pkt                  r_mem [rcbind_pkg::Q_DEPTH];
    logic [rcbind_pkg::Q_PTR_W-1:0]    r_wr, r_rd;
    logic [rcbind_pkg::Q_CNT_W-1:0]    r_cnt;

    assign o_ready    = (r_cnt != rcbind_pkg::Q_CNT_W'(rcbind_pkg::Q_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/rcbind_back.sv @@
// back end: walks queued packets, one word per cycle to the output reg unless stalled
`timescale 1ns / 1ps

module rcbind_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_nonempty,
    input  rcbind_pkg::t_pkt     i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [15:0]          o_data,
    output logic [3:0]           o_user,
    output logic                 o_last
);

    logic [rcbind_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                          r_o_vld;
    logic [7:0]                    r_o_byte;
    logic [rcbind_pkg::IDX_W-1:0]  r_o_idx;
    logic [3:0]                    r_o_user;
    logic                          r_o_last;
    logic                          fire;
    logic                          last;

    assign fire = i_nonempty && (!r_o_vld || i_ready);
    assign last = (r_idx == (i_head.nbytes - 1'b1));

    always_comb begin
        n_idx = r_idx;
        o_pop = 1'b0;
        if (fire) begin
            if (last) begin
                n_idx = '0;
                o_pop = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (fire) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_byte <= i_head.bytes[r_idx];
            r_o_idx  <= r_idx;
            r_o_user <= {i_head.done, i_head.soon, i_head.bind_addr, i_head.sending};
            r_o_last <= last;
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = {4'd0, r_o_idx, r_o_byte};
    assign o_user  = r_o_user;
    assign o_last  = r_o_last;

endmodule

@@ rtl/core/rc_bind_and_control_packet_tx_unit.sv @@
// top level of the rc bind and control packet transmitter
// the first word of a tick goes through stage a, the queue and the output register in turn
// a packet tick is 8 or 9 words, an empty tick one, sent one word per cycle when not stalled
//   through the single output register; ticks are taken every cycle while the queue has room
// reset: synchronous active low; link goes to the initial phase, queue empties,
//   registers return to format 0, auto-ack on, id 0, 60 bind repeats
`timescale 1ns / 1ps

module rc_bind_and_control_packet_tx_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [rcbind_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [31:0]                          i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // aileron_in, elevator_in, throttle_in, rudder_in, flip_on, light_on,
    // picture_on, video_on, headless_on, ack_status, pad
    input  logic [71:0]                          s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // packet_byte, byte_index, pad
    output logic [15:0]                          m_axis_tdata,
    // sending, use_bind_address, recheck_soon, bind_done
    output logic [3:0]                           m_axis_tuser,
    // last_of_run
    output logic                                 m_axis_tlast
);

    rcbind_pkg::t_cfg  r_cfg;
    rcbind_pkg::t_pkt  push_pkt, head_pkt;
    logic              push, pop, q_ready, q_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt          <= rcbind_pkg::FMT_BASE;
            r_cfg.auto_ack_off <= 1'b0;
            r_cfg.tx_id        <= 32'd0;
            r_cfg.bind_rep     <= rcbind_pkg::BIND_REP_RESET;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                rcbind_pkg::CFG_FORMAT:   r_cfg.fmt          <= i_cfg_wdata[2:0];
                rcbind_pkg::CFG_AUTO_ACK: r_cfg.auto_ack_off <= i_cfg_wdata[0];
                rcbind_pkg::CFG_TX_ID:    r_cfg.tx_id        <= i_cfg_wdata;
                rcbind_pkg::CFG_BIND_REP: r_cfg.bind_rep     <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    rcbind_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata[70:0]),
        .o_push    (push),
        .o_pkt     (push_pkt),
        .i_q_ready (q_ready)
    );

    rcbind_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pkt      (push_pkt),
        .o_ready    (q_ready),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_head     (head_pkt)
    );

    rcbind_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_head     (head_pkt),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_user     (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

endmodule
